// ===== rtl/hc27_pkg.sv =====
// Shared types and constants for the 27-symbol Huffman codec.
package hc27_pkg;
  localparam int Symbols = 27;
  localparam int Nodes = 53;
  localparam int Merges = 26;
  localparam int CodeBits = 26;
  localparam int LenBits = 5;
  localparam int NodeIdxBits = 6;
  localparam int DefWeightBits = 16;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ENCODED  = 3'd0,
    ST_DECODED  = 3'd1,
    ST_NOTREADY = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_UNFIN    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_BAD  = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
    logic [15:0] weight;
    logic       code_bit;
    logic       last_bit;
  } cmd_t;
endpackage

// ===== rtl/hc27_front.sv =====
// Front end: accepts items, classifies them and folds characters to indexes.
module hc27_front import hc27_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] weight_i,
  input  logic [7:0]  character_i,
  input  logic        code_bit_i,
  input  logic        last_bit_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output cmd_t        q_cmd_o
);
  cmd_t q_mem [QueueDepth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t cmd;
  logic [7:0] ch;
  logic push, pop;

  always_comb begin
    ch = character_i;
    if (ch >= 8'h41 && ch <= 8'h5a) ch = ch + 8'd32;
    cmd.weight = weight_i;
    cmd.code_bit = code_bit_i;
    cmd.last_bit = last_bit_i;
    cmd.idx = '0;
    cmd.op = OP_LOAD;
    unique case (mode_e'(mode_i))
      MODE_LOAD: cmd.op = OP_LOAD;
      MODE_DEC:  cmd.op = OP_DEC;
      MODE_ENC: begin
        if (ch == 8'h20) cmd.op = OP_ENC;
        else if (ch >= 8'h61 && ch <= 8'h7a) begin
          cmd.op = OP_ENC;
          cmd.idx = 5'(ch - 8'h60);
        end else cmd.op = OP_BAD;
      end
      default: cmd.op = OP_LOAD;
    endcase
  end

  assign stall_o = (cnt_q == 2'(QueueDepth));
  assign push = valid_i && !stall_o && (mode_e'(mode_i) != MODE_NOP);
  assign pop = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QueueDepth)) |-> !push) else $error("push into full queue");
`endif
endmodule

// ===== rtl/hc27_back.sv =====
// Back end: weight store, sequential tree build, code table, encode and decode.
module hc27_back import hc27_pkg::*; #(
  parameter int WeightBits = DefWeightBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  cmd_t        q_cmd_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  symbol_o,
  output logic [25:0] code_word_o,
  output logic [4:0]  code_length_o
);
  localparam int NW = WeightBits + 5;
  localparam int LW = (WeightBits < 16) ? WeightBits : 16;

  typedef enum logic [2:0] {S_RUN, S_SCAN, S_MERGE, S_WALK, S_WALK2} st_e;
  st_e st_q;

  // leaf nodes 0..26 and merged nodes 27..52 are kept apart
  logic [NW-1:0] lw_q [Symbols];
  logic [NW-1:0] iw_q [Merges];
  logic [Nodes-1:0] taken_q;
  logic [NodeIdxBits-1:0] fc_q [Merges];
  logic [NodeIdxBits-1:0] sc_q [Merges];
  logic [CodeBits-1:0] lc_q [Symbols];
  logic [LenBits-1:0] ll_q [Symbols];
  logic [CodeBits-1:0] ic_q [Merges];
  logic [LenBits-1:0] il_q [Merges];
  logic [4:0] load_q;
  logic ready_q;
  logic [CodeBits-1:0] pb_q;
  logic [LenBits-1:0] pl_q;
  logic [NodeIdxBits-1:0] total_q, scan_q, best_q, first_q;
  logic found_q, second_q;
  logic [4:0] merge_q;

  logic out_v_q, out_v_d;
  logic [2:0] o_st_q;
  logic [7:0] o_sym_q;
  logic [25:0] o_cw_q;
  logic [4:0] o_len_q;

  logic free;
  logic [CodeBits-1:0] nb;
  logic [LenBits-1:0] nl;
  logic hit;
  logic [4:0] hit_i;
  logic [NodeIdxBits-1:0] ca, cb;
  logic [NW-1:0] w_scan, w_best, w_first;
  logic [4:0] ld_idx;

  assign free = !out_v_q || !stall_i;
  assign q_pop_o = (st_q == S_RUN) && q_valid_i && free;
  assign nb = {pb_q[CodeBits-2:0], q_cmd_i.code_bit};
  assign nl = pl_q + 5'd1;
  assign ca = fc_q[merge_q];
  assign cb = sc_q[merge_q];
  assign ld_idx = ready_q ? 5'd0 : load_q;

  always_comb begin
    w_scan = (scan_q < 6'(Symbols)) ? lw_q[scan_q[4:0]] : iw_q[5'(scan_q - 6'(Symbols))];
    w_best = (best_q < 6'(Symbols)) ? lw_q[best_q[4:0]] : iw_q[5'(best_q - 6'(Symbols))];
    w_first = (first_q < 6'(Symbols)) ? lw_q[first_q[4:0]]
                                      : iw_q[5'(first_q - 6'(Symbols))];
  end

  always_comb begin
    hit = 1'b0;
    hit_i = '0;
    for (int i = Symbols - 1; i >= 0; i--) begin
      if (ll_q[i] == nl && lc_q[i] == nb) begin
        hit = 1'b1;
        hit_i = 5'(i);
      end
    end
  end

  always_comb begin
    out_v_d = out_v_q && stall_i;
    if (q_pop_o) begin
      case (q_cmd_i.op) inside
        OP_ENC, OP_BAD: out_v_d = 1'b1;
        OP_DEC: out_v_d = !ready_q || hit || q_cmd_i.last_bit;
        default: out_v_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.op == OP_LOAD) lw_q[ld_idx] <= NW'(q_cmd_i.weight[LW-1:0]);
    if (st_q == S_MERGE && second_q) begin
      iw_q[merge_q] <= w_first + w_best;
      fc_q[merge_q] <= first_q;
      sc_q[merge_q] <= best_q;
    end
    if (st_q == S_WALK) begin
      if (merge_q == 5'(Merges - 1)) begin
        ic_q[merge_q] <= '0;
        il_q[merge_q] <= '0;
      end
    end
    if (st_q == S_WALK2) begin
      if (ca < 6'(Symbols)) begin
        lc_q[ca[4:0]] <= {ic_q[merge_q][CodeBits-2:0], 1'b1};
        ll_q[ca[4:0]] <= il_q[merge_q] + 5'd1;
      end else begin
        ic_q[5'(ca - 6'(Symbols))] <= {ic_q[merge_q][CodeBits-2:0], 1'b1};
        il_q[5'(ca - 6'(Symbols))] <= il_q[merge_q] + 5'd1;
      end
      if (cb < 6'(Symbols)) begin
        lc_q[cb[4:0]] <= {ic_q[merge_q][CodeBits-2:0], 1'b0};
        ll_q[cb[4:0]] <= il_q[merge_q] + 5'd1;
      end else begin
        ic_q[5'(cb - 6'(Symbols))] <= {ic_q[merge_q][CodeBits-2:0], 1'b0};
        il_q[5'(cb - 6'(Symbols))] <= il_q[merge_q] + 5'd1;
      end
    end
    if (free && q_pop_o) begin
      o_sym_q <= '0;
      o_cw_q <= '0;
      o_len_q <= '0;
      unique case (q_cmd_i.op)
        OP_ENC: begin
          o_st_q <= ready_q ? ST_ENCODED : ST_NOTREADY;
          if (ready_q) begin
            o_cw_q <= lc_q[q_cmd_i.idx];
            o_len_q <= ll_q[q_cmd_i.idx];
          end
        end
        OP_BAD: o_st_q <= ready_q ? ST_BADCHAR : ST_NOTREADY;
        OP_DEC: begin
          o_st_q <= !ready_q ? ST_NOTREADY : (hit ? ST_DECODED : ST_UNFIN);
          if (ready_q) begin
            o_cw_q <= nb;
            o_len_q <= nl;
            if (hit) o_sym_q <= (hit_i == 5'd0) ? 8'h20 : 8'h60 + 8'(hit_i);
          end
        end
        default: o_st_q <= ST_ENCODED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_RUN;
      load_q <= '0;
      ready_q <= 1'b0;
      pb_q <= '0;
      pl_q <= '0;
      total_q <= '0;
      scan_q <= '0;
      best_q <= '0;
      first_q <= '0;
      found_q <= 1'b0;
      second_q <= 1'b0;
      merge_q <= '0;
      taken_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      unique case (st_q)
        S_RUN: if (q_pop_o) begin
          unique case (q_cmd_i.op)
            OP_LOAD: begin
              load_q <= ld_idx + 5'd1;
              if (ready_q) begin
                ready_q <= 1'b0;
                pb_q <= '0;
                pl_q <= '0;
              end
              if (!ready_q && load_q == 5'(Symbols - 1)) begin
                st_q <= S_SCAN;
                taken_q <= '0;
                total_q <= NodeIdxBits'(Symbols);
                scan_q <= '0;
                found_q <= 1'b0;
                second_q <= 1'b0;
                merge_q <= '0;
              end
            end
            OP_DEC: begin
              if (ready_q) begin
                if (hit || q_cmd_i.last_bit || nl >= 5'd26) begin
                  pb_q <= '0;
                  pl_q <= '0;
                end else begin
                  pb_q <= nb;
                  pl_q <= nl;
                end
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (!taken_q[scan_q] && (!found_q || w_scan < w_best)) begin
            best_q <= scan_q;
            found_q <= 1'b1;
          end
          if (scan_q == total_q - 6'd1) st_q <= S_MERGE;
          else scan_q <= scan_q + 6'd1;
        end
        S_MERGE: begin
          taken_q[best_q] <= 1'b1;
          scan_q <= '0;
          found_q <= 1'b0;
          if (!second_q) begin
            first_q <= best_q;
            second_q <= 1'b1;
            st_q <= S_SCAN;
          end else begin
            second_q <= 1'b0;
            total_q <= total_q + 6'd1;
            if (merge_q == 5'(Merges - 1)) st_q <= S_WALK;
            else begin
              merge_q <= merge_q + 5'd1;
              st_q <= S_SCAN;
            end
          end
        end
        S_WALK: st_q <= S_WALK2;
        S_WALK2: begin
          if (merge_q == 5'd0) begin
            st_q <= S_RUN;
            ready_q <= 1'b1;
          end else begin
            merge_q <= merge_q - 5'd1;
            st_q <= S_WALK;
          end
        end
        default: st_q <= S_RUN;
      endcase
    end
  end

  assign valid_o = out_v_q;
  assign status_o = o_st_q;
  assign symbol_o = o_sym_q;
  assign code_word_o = o_cw_q;
  assign code_length_o = o_len_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && stall_i) |=> out_v_q) else $error("result dropped");
  a_build_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_RUN) |-> !q_pop_o) else $error("pop during build");
  a_ready_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(st_q == S_WALK2)) else $error("ready without build");
`endif
endmodule

// ===== rtl/huffman_codec_27_symbols.sv =====
// Top level of the 27-symbol Huffman codec.
// Encode and decode items: one per cycle while no build runs and neither stall holds;
// each passes the input queue and its result is registered. The 27th load item starts a tree
// build: 26 merges of two lightest-node scans over 27+m nodes, then a walk down the merges.
// Reset (async, active low) clears counters, the ready flag, queue and decode prefix.
module huffman_codec_27_symbols import hc27_pkg::*; #(
  parameter int WeightBits = DefWeightBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] weight_i,
  input  logic [7:0]  character_i,
  input  logic        code_bit_i,
  input  logic        last_bit_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  symbol_o,
  output logic [25:0] code_word_o,
  output logic [4:0]  code_length_o
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  hc27_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .weight_i, .character_i,
    .code_bit_i, .last_bit_i, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  hc27_back #(.WeightBits(WeightBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .valid_o, .stall_i, .status_o, .symbol_o, .code_word_o, .code_length_o
  );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 27-symbol Huffman codec: queued driver, predictor, monitor.
module tb_top;
  import hc27_pkg::*;

  typedef logic [15:0] weight_set_t [Symbols];
  typedef logic [25:0] code_bits_t [Symbols];
  typedef int unsigned code_len_t [Symbols];

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] weight;
    logic [7:0]  chr;
    logic        cbit;
    logic        lbit;
    bit          sync;
  } item_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  symbol;
    logic [25:0] word;
    logic [4:0]  len;
  } result_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7a;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5a;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  mode_i = '0;
  logic [15:0] weight_i = '0;
  logic [7:0]  character_i = '0;
  logic        code_bit_i = 1'b0;
  logic        last_bit_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  symbol_o;
  logic [25:0] code_word_o;
  logic [4:0]  code_length_o;

  huffman_codec_27_symbols DUT (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .weight_i, .character_i,
    .code_bit_i, .last_bit_i, .valid_o, .stall_i, .status_o, .symbol_o,
    .code_word_o, .code_length_o
  );

  always #10 clk_i = ~clk_i;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  int      accepted_count = 0;
  int      hold_left = 0;

  // predictor state
  int unsigned load_cnt = 0;
  bit          tbl_ready = 0;
  weight_set_t cur_weights;
  code_bits_t  tbl_bits;
  code_len_t   tbl_len;
  logic [25:0] prefix_bits = '0;
  int unsigned prefix_len = 0;

  function automatic void build_codes(input weight_set_t w, output code_bits_t cb,
                                      output code_len_t cl);
    logic [31:0] nwt [Nodes];
    bit          tk [Nodes];
    int          fc [Merges];
    int          sc [Merges];
    logic [25:0] c [Nodes];
    int unsigned l [Nodes];
    int          total, best, pick;
    bit          found;
    for (int i = 0; i < Nodes; i++) begin
      nwt[i] = (i < Symbols) ? 32'(w[i]) : '0;
      tk[i] = 0;
      c[i] = '0;
      l[i] = 0;
    end
    total = Symbols;
    for (int m = 0; m < Merges; m++) begin
      for (int k = 0; k < 2; k++) begin
        best = 0;
        found = 0;
        for (int i = 0; i < total; i++)
          if (!tk[i] && (!found || nwt[i] < nwt[best])) begin
            best = i;
            found = 1;
          end
        tk[best] = 1;
        if (k == 0) fc[m] = best;
        else sc[m] = best;
      end
      nwt[Symbols + m] = nwt[fc[m]] + nwt[sc[m]];
      total = Symbols + m + 1;
    end
    for (int p = Nodes - 1; p >= Symbols; p--) begin
      pick = fc[p - Symbols];
      c[pick] = {c[p][24:0], 1'b1};
      l[pick] = l[p] + 1;
      pick = sc[p - Symbols];
      c[pick] = {c[p][24:0], 1'b0};
      l[pick] = l[p] + 1;
    end
    for (int i = 0; i < Symbols; i++) begin
      cb[i] = c[i];
      cl[i] = l[i] & 31;
    end
  endfunction

  function automatic result_t mk_result(logic [2:0] st, logic [7:0] sy, logic [25:0] wd,
                                        logic [4:0] ln);
    result_t r;
    r.status = st;
    r.symbol = sy;
    r.word = wd;
    r.len = ln;
    return r;
  endfunction

  task automatic predict_codec(input item_t it);
    logic [7:0] ch;
    int idx;
    bit hit;
    if (it.mode == MODE_LOAD) begin
      if (tbl_ready) begin
        tbl_ready = 0;
        load_cnt = 0;
        prefix_bits = '0;
        prefix_len = 0;
      end
      if (load_cnt < Symbols) begin
        cur_weights[load_cnt] = it.weight;
        load_cnt++;
        if (load_cnt == Symbols) begin
          build_codes(cur_weights, tbl_bits, tbl_len);
          tbl_ready = 1;
        end
      end
    end else if (it.mode == MODE_NOP) begin
    end else if (!tbl_ready) begin
      expected_results.push_back(mk_result(ST_NOTREADY, '0, '0, '0));
    end else if (it.mode == MODE_ENC) begin
      ch = it.chr;
      if (ch >= ChUpA && ch <= ChUpZ) ch = ch + 8'd32;
      if (ch == ChSpace) idx = 0;
      else if (ch >= ChLowA && ch <= ChLowZ) idx = ch - ChLowA + 1;
      else idx = -1;
      if (idx < 0) expected_results.push_back(mk_result(ST_BADCHAR, '0, '0, '0));
      else expected_results.push_back(mk_result(ST_ENCODED, '0, tbl_bits[idx],
                                                5'(tbl_len[idx])));
    end else begin
      prefix_bits = {prefix_bits[24:0], it.cbit};
      prefix_len++;
      hit = 0;
      for (int i = 0; i < Symbols && !hit; i++)
        if (tbl_len[i] == prefix_len && tbl_bits[i] == prefix_bits) begin
          hit = 1;
          expected_results.push_back(mk_result(ST_DECODED,
              (i == 0) ? ChSpace : 8'(ChLowA + i - 1), prefix_bits, 5'(prefix_len)));
        end
      if (hit || it.lbit) begin
        if (!hit)
          expected_results.push_back(mk_result(ST_UNFIN, '0, prefix_bits, 5'(prefix_len)));
        prefix_bits = '0;
        prefix_len = 0;
      end else if (prefix_len >= 26) begin
        prefix_bits = '0;
        prefix_len = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // stimulus generation
  code_bits_t gen_bits;
  code_len_t  gen_len;

  function automatic item_t rand_item(logic [1:0] md);
    item_t it;
    it.mode = md;
    it.weight = 16'($urandom);
    it.chr = 8'($urandom);
    it.cbit = 1'($urandom);
    it.lbit = 1'($urandom);
    it.sync = 0;
    return it;
  endfunction

  task automatic push_enc(input logic [7:0] ch);
    item_t it;
    it = rand_item(MODE_ENC);
    it.chr = ch;
    pending_items.push_back(it);
  endtask

  task automatic push_bit(input logic b, input logic l);
    item_t it;
    it = rand_item(MODE_DEC);
    it.cbit = b;
    it.lbit = l;
    pending_items.push_back(it);
  endtask

  task automatic push_loads(input weight_set_t w, input int upto);
    item_t it;
    for (int i = 0; i < upto; i++) begin
      it = rand_item(MODE_LOAD);
      it.weight = w[i];
      pending_items.push_back(it);
    end
    if (upto == Symbols) build_codes(w, gen_bits, gen_len);
  endtask

  // sends a symbol's code; cut > 0 sends at most cut bits, with last set on the final bit sent
  task automatic push_code(input int sym, input logic last_end, input int cut);
    int n;
    n = (cut > 0 && cut < gen_len[sym]) ? cut : gen_len[sym];
    for (int k = 0; k < n; k++)
      push_bit(gen_bits[sym][gen_len[sym] - 1 - k],
               (k == n - 1) ? ((cut > 0) ? 1'b1 : last_end) : 1'b0);
  endtask

  function automatic weight_set_t rand_weights();
    weight_set_t w;
    int kind;
    int unsigned a, b, t;
    logic [15:0] tmp;
    kind = $urandom_range(0, 5);
    a = 1;
    b = 1;
    for (int i = 0; i < Symbols; i++) begin
      case (kind)
        0: w[i] = 16'($urandom);
        1: w[i] = 16'($urandom_range(0, 7));
        2: begin
          w[i] = (a > 65535) ? 16'hffff : 16'(a);
          t = a + b;
          a = b;
          b = t;
        end
        3: w[i] = 16'hffff;
        4: w[i] = 16'd0;
        default: w[i] = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(0, 300));
      endcase
    end
    if (kind == 2 && $urandom_range(0, 1)) begin
      for (int i = 0; i < Symbols / 2; i++) begin
        tmp = w[i];
        w[i] = w[Symbols - 1 - i];
        w[Symbols - 1 - i] = tmp;
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'(ChLowA + $urandom_range(0, 25));
    if (r < 5) return 8'(ChUpA + $urandom_range(0, 25));
    if (r < 6) return ChSpace;
    return 8'($urandom);
  endfunction

  initial begin
    weight_set_t w;
    item_t it;
    int act;
    // directed part
    push_enc(ChLowA);
    push_bit(1'b1, 1'b1);
    pending_items.push_back(rand_item(MODE_NOP));
    for (int i = 0; i < Symbols; i++) w[i] = (i % 3 == 0) ? 16'hffff : 16'(i);
    w[5] = 16'd0;
    push_loads(w, Symbols);
    push_enc(ChSpace);
    push_enc(ChUpA);
    push_enc(ChLowZ);
    push_enc(ChUpZ);
    push_enc(8'h40);
    push_enc(8'h5b);
    push_enc(8'h00);
    push_enc(8'hff);
    push_code(0, 1'b1, 0);
    push_code(26, 1'b0, 0);
    push_code(5, 1'b0, 1);
    pending_items.push_back(rand_item(MODE_NOP));
    // random part
    while (pending_items.size() < 1800) begin
      w = rand_weights();
      if ($urandom_range(0, 3) == 0) begin
        push_code($urandom_range(0, 26), 1'b0, 1);
        push_loads(w, $urandom_range(1, 26));
        push_enc(rand_char());
        push_bit(1'($urandom), 1'b1);
        w = rand_weights();
        pending_items.push_back(rand_item(MODE_LOAD));
        it = pending_items.pop_back();
        it.weight = w[0];
        pending_items.push_back(it);
        for (int i = 1; i < Symbols; i++) begin
          it = rand_item(MODE_LOAD);
          it.weight = w[i];
          pending_items.push_back(it);
        end
        build_codes(w, gen_bits, gen_len);
      end else begin
        if (pending_items.size() > 300 && $urandom_range(0, 2) == 0) begin
          it = rand_item(MODE_LOAD);
          it.weight = w[0];
          it.sync = 1;
          pending_items.push_back(it);
          for (int i = 1; i < Symbols; i++) begin
            it = rand_item(MODE_LOAD);
            it.weight = w[i];
            pending_items.push_back(it);
          end
          build_codes(w, gen_bits, gen_len);
        end else begin
          push_loads(w, Symbols);
        end
      end
      for (int n = 0; n < 60; n++) begin
        act = $urandom_range(0, 19);
        if (act < 7) push_enc(rand_char());
        else if (act < 15) push_code($urandom_range(0, 26), 1'($urandom), 0);
        else if (act < 17) push_code($urandom_range(0, 26), 1'b0, $urandom_range(1, 3));
        else if (act < 19) push_bit(1'($urandom), 1'($urandom));
        else pending_items.push_back(rand_item(MODE_NOP));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  int   burst_left = 0;
  int   gap_left = 0;
  item_t cur_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin : drive
      bit nv;
      if (valid_i && !stall_o) begin
        predict_codec(cur_item);
        accepted_count++;
      end
      if (valid_i && stall_o) begin
        nv = 1'b1;
      end else begin
        nv = 1'b0;
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].sync && expected_results.size() > 0)) begin
          cur_item = pending_items.pop_front();
          mode_i <= cur_item.mode;
          weight_i <= cur_item.weight;
          character_i <= cur_item.chr;
          code_bit_i <= cur_item.cbit;
          last_bit_i <= cur_item.lbit;
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      valid_i <= nv;
    end
  end

  // receiver stall pattern
  int  pat_sel = 0;
  int  pat_cnt = 0;
  bit  hold_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else if (!hold_done && accepted_count >= 700) begin
      hold_done = 1;
      hold_left = 300;
      stall_i <= 1'b1;
    end else begin
      if (pat_cnt == 0) begin
        pat_sel = $urandom_range(0, 3);
        pat_cnt = $urandom_range(16, 96);
      end else begin
        pat_cnt--;
      end
      case (pat_sel)
        0: stall_i <= 1'b0;
        1: stall_i <= 1'($urandom);
        2: stall_i <= ($urandom_range(0, 3) == 0);
        default: stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(status_o), '0);
      end else begin : chk
        result_t r;
        r = expected_results.pop_front();
        if (status_o !== r.status)
          report_mismatch("status", 32'(status_o), 32'(r.status));
        if (symbol_o !== r.symbol)
          report_mismatch("symbol", 32'(symbol_o), 32'(r.symbol));
        if (code_word_o !== r.word)
          report_mismatch("code_word", 32'(code_word_o), 32'(r.word));
        if (code_length_o !== r.len)
          report_mismatch("code_length", 32'(code_length_o), 32'(r.len));
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (pending_items.size() == 0 && !valid_i && expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (expected_results.size() > 0)
      report_mismatch("results left over", expected_results.size(), '0);
    if (errors == 0) begin
      $display("huffman_codec_27_symbols verification clean");
    end else begin
      $display("huffman_codec_27_symbols verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("huffman_codec_27_symbols verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/hc27_pkg.sv
rtl/hc27_front.sv
rtl/hc27_back.sv
rtl/huffman_codec_27_symbols.sv
tb/tb_top.sv
